>>> hdl/bba_pkg.sv
// ============================================================================
// bba_pkg
// Shared widths and result status codes of the buddy block allocator.
// ============================================================================
`default_nettype none

package bba_pkg;

    localparam int REQ_W       = 17;
    localparam int POOL_W      = 17;
    localparam int BOUND_OUT_W = 16;
    localparam int STAT_W      = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 2 * BOUND_OUT_W;

    localparam logic [POOL_W-1:0] POOL_RESET = 17'd65536;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

endpackage

`default_nettype wire

>>> hdl/buddy_block_allocator_unit.sv
// ============================================================================
// buddy_block_allocator_unit
// Buddy allocator, grant side only: one FIFO free list per order, search up,
// split down, report the granted bounds.
// ============================================================================
// Input stream: s_tdata[16:0] carries request_size. Output stream: m_tuser
// carries status (0 granted, 1 no block large enough), m_tdata carries
// block_low (bits 15:0) and block_high (bits 31:16), both zero unless granted.
// pool_size_we/pool_size_wdata write the pool size and reload one free block
// covering the whole pool, with s_tready low during the reload.
// A sequencer drives one list memory (one write and one read port) and one
// subtract/halve unit: accept the request, search one order at a time from
// the request order up to the first non-empty list, read the head block from
// memory, split one level per step down to the request order, then load the
// output register.
// Oversized requests skip the search and go straight to the output step; with
// no free block large enough a request searches up to MAX_ORDER, then status 1.
// Reset loads the pool at 65536 units and starts in the reload state.
// s_tready is high only while idle. The result sits in the output register
// until taken; a stalled receiver holds the sequencer in its final step.
// ============================================================================
`default_nettype none

module buddy_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAX_ORDER  = 16,
    parameter int LIST_DEPTH = 64
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [S_TDATA_W-1:0]   s_tdata,          // [16:0] request_size
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,          // [15:0] block_low, [31:16] block_high
    output logic [STAT_W-1:0]      m_tuser,          // [1:0] status
    input  wire                    pool_size_we,
    input  wire  [POOL_W-1:0]      pool_size_wdata
);

    localparam int NUM_LISTS = MAX_ORDER + 1;
    localparam int BW        = MAX_ORDER;
    localparam int LVL_W     = $clog2(NUM_LISTS);
    localparam int SLOT_W    = $clog2(LIST_DEPTH);
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int PW        = (MAX_ORDER + 1 > POOL_W) ? MAX_ORDER + 1 : POOL_W;
    localparam logic [PW-1:0] POOL_CAP = PW'(1) << MAX_ORDER;

    typedef enum logic [5:0] {
        ST_LOAD   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SEARCH = 6'b000100,
        ST_READ   = 6'b001000,
        ST_SPLIT  = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    function automatic logic [5:0] ceil_log2(input logic [PW-1:0] n);
        logic [PW-1:0] v;
        logic [5:0]    r;
        v = n - PW'(1);
        r = '0;
        if (n > PW'(1))
        begin
            for (int i = 0; i < PW; i++)
            begin
                if (v[i])
                begin
                    r = 6'(i + 1);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] list_addr(input logic [LVL_W-1:0] l,
                                                    input logic [SLOT_W-1:0] s);
        return ADDR_W'(l) * ADDR_W'(LIST_DEPTH) + ADDR_W'(s);
    endfunction

    state_t                 state_reg, state_next;
    logic [POOL_W-1:0]      pool_reg;
    logic [CNT_W-1:0]       count_reg [NUM_LISTS];
    logic [CNT_W-1:0]       count_next [NUM_LISTS];
    logic [SLOT_W-1:0]      head_reg [NUM_LISTS];
    logic [SLOT_W-1:0]      head_next [NUM_LISTS];
    logic [LVL_W-1:0]       lvl_reg, lvl_next;
    logic [LVL_W-1:0]       tgt_reg, tgt_next;
    logic [BW-1:0]          blk_lo_reg, blk_lo_next;
    logic [BW-1:0]          blk_hi_reg, blk_hi_next;
    logic [STAT_W-1:0]      res_stat_reg, res_stat_next;
    logic [BOUND_OUT_W-1:0] res_lo_reg, res_lo_next;
    logic [BOUND_OUT_W-1:0] res_hi_reg, res_hi_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [STAT_W-1:0]      m_tuser_reg, m_tuser_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [2*BW-1:0]        mem [MEM_DEPTH];
    logic [2*BW-1:0]        rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [2*BW-1:0]        mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    logic [PW-1:0]          pool_cl;
    logic [LVL_W-1:0]       load_ord;
    logic [5:0]             req_ord;
    logic [LVL_W-1:0]       dn_lvl;
    logic [BW:0]            span_w;
    logic [BW:0]            span_w1;
    logic [CNT_W:0]         push_sum;
    logic [SLOT_W-1:0]      push_slot;

    assign pool_cl  = (PW'(pool_reg) > POOL_CAP) ? POOL_CAP : PW'(pool_reg);
    assign load_ord = LVL_W'(ceil_log2(pool_cl));
    assign req_ord  = ceil_log2(PW'(s_tdata[REQ_W-1:0]));

    assign dn_lvl   = lvl_reg - LVL_W'(1);
    assign span_w   = (BW+1)'(blk_hi_reg) - (BW+1)'(blk_lo_reg);
    assign span_w1  = span_w + (BW+1)'(1);
    assign push_sum = (CNT_W+1)'(head_reg[dn_lvl]) + (CNT_W+1)'(count_reg[dn_lvl]);
    assign push_slot = (push_sum >= (CNT_W+1)'(LIST_DEPTH))
                       ? SLOT_W'(push_sum - (CNT_W+1)'(LIST_DEPTH)) : SLOT_W'(push_sum);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        lvl_next      = lvl_reg;
        tgt_next      = tgt_reg;
        blk_lo_next   = blk_lo_reg;
        blk_hi_next   = blk_hi_reg;
        res_stat_next = res_stat_reg;
        res_lo_next   = res_lo_reg;
        res_hi_next   = res_hi_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                for (int i = 0; i < NUM_LISTS; i++)
                begin
                    count_next[i] = '0;
                    head_next[i]  = '0;
                end
                if (pool_cl != '0)
                begin
                    count_next[load_ord] = CNT_W'(1);
                    mem_we    = 1'b1;
                    mem_waddr = list_addr(load_ord, '0);
                    mem_wdata = {BW'(pool_cl - PW'(1)), BW'(0)};
                end
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (32'(req_ord) > MAX_ORDER)
                    begin
                        res_stat_next = STAT_NOSPACE;
                        res_lo_next   = '0;
                        res_hi_next   = '0;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        lvl_next   = LVL_W'(req_ord);
                        tgt_next   = LVL_W'(req_ord);
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (count_reg[lvl_reg] != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = list_addr(lvl_reg, head_reg[lvl_reg]);
                    head_next[lvl_reg] = (head_reg[lvl_reg] == SLOT_W'(LIST_DEPTH - 1))
                                         ? '0 : head_reg[lvl_reg] + SLOT_W'(1);
                    count_next[lvl_reg] = count_reg[lvl_reg] - CNT_W'(1);
                    state_next = ST_READ;
                end
                else if (lvl_reg == LVL_W'(MAX_ORDER))
                begin
                    res_stat_next = STAT_NOSPACE;
                    res_lo_next   = '0;
                    res_hi_next   = '0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end
            ST_READ:
            begin
                blk_lo_next = rd_data_reg[BW-1:0];
                blk_hi_next = rd_data_reg[2*BW-1:BW];
                state_next  = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                if (lvl_reg == tgt_reg)
                begin
                    res_stat_next = STAT_OK;
                    res_lo_next   = BOUND_OUT_W'(blk_lo_reg);
                    res_hi_next   = BOUND_OUT_W'(blk_hi_reg);
                    state_next    = ST_EMIT;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = list_addr(dn_lvl, push_slot);
                    mem_wdata = {blk_hi_reg,
                                 BW'((BW+1)'(blk_lo_reg) + (span_w1 >> 1))};
                    count_next[dn_lvl] = count_reg[dn_lvl] + CNT_W'(1);
                    blk_hi_next = BW'((BW+1)'(blk_lo_reg) + (span_w >> 1));
                    lvl_next    = dn_lvl;
                end
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_stat_reg;
                    m_tdata_next  = {res_hi_reg, res_lo_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (pool_size_we)
        begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            pool_reg     <= POOL_RESET;
            m_tvalid_reg <= 1'b0;
            lvl_reg      <= '0;
            tgt_reg      <= '0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            lvl_reg      <= lvl_next;
            tgt_reg      <= tgt_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            if (pool_size_we)
            begin
                pool_reg <= pool_size_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_lo_reg   <= blk_lo_next;
        blk_hi_reg   <= blk_hi_next;
        res_stat_reg <= res_stat_next;
        res_lo_reg   <= res_lo_next;
        res_hi_reg   <= res_hi_next;
        m_tuser_reg  <= m_tuser_next;
        m_tdata_reg  <= m_tdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/bba_checker.sv
// ============================================================================
// bba_checker
// Port-level checks of the buddy block allocator, bound to the top level.
// ============================================================================
`default_nettype none

module bba_checker
    import bba_pkg::*;
(
    input wire                   clk,
    input wire                   rst_n,
    input wire                   s_tvalid,
    input wire                   s_tready,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [M_TDATA_W-1:0]   m_tdata,
    input wire [STAT_W-1:0]      m_tuser,
    input wire                   pool_size_we
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transfer changed while stalled");

    a_no_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != STAT_FULL)
        else $error("list full status on a search that only pushes onto empty lists");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0)
        else $error("refused request carries nonzero bounds");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted transfer");

    a_reload_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pool_size_we |=> !s_tready)
        else $error("input ready during pool reload");

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .pool_size_we (pool_size_we)
);

`default_nettype wire

>>> tb/buddy_block_allocator_unit_checker.sv
// ----------------------------------------------------------------------------
// Buddy allocator result checker
// Watches the request, result and pool-size channels of the allocator. Keeps
// its own free lists per order, works out the grant for every request that
// transfers, and compares each result that transfers with the oldest grant due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buddy_block_allocator_unit_checker
    import bba_pkg::*;
#(
    parameter int MAX_ORDER  = 16,
    parameter int LIST_DEPTH = 64
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    input  wire                  s_tready,
    input  wire  [S_TDATA_W-1:0] s_tdata,
    input  wire                  m_tvalid,
    input  wire                  m_tready,
    input  wire  [M_TDATA_W-1:0] m_tdata,
    input  wire  [STAT_W-1:0]    m_tuser,
    input  wire                  pool_size_we,
    input  wire  [POOL_W-1:0]    pool_size_wdata,
    output int                   mismatch_count,
    output int                   grant_count,
    output logic                 grants_pending
);

    localparam int NUM_LISTS = MAX_ORDER + 1;

    typedef struct packed {
        logic [STAT_W-1:0]      status;
        logic [BOUND_OUT_W-1:0] block_high;
        logic [BOUND_OUT_W-1:0] block_low;
    } grant_t;

    int unsigned span_lo [NUM_LISTS][LIST_DEPTH];
    int unsigned span_hi [NUM_LISTS][LIST_DEPTH];
    int unsigned list_head [NUM_LISTS];
    int unsigned list_count [NUM_LISTS];
    grant_t      grants_due [$];
    int          fails = 0;
    int          grants = 0;

    assign mismatch_count = fails;
    assign grant_count    = grants;

    function automatic int unsigned order_for(longint unsigned units);
        int unsigned k;
        k = 0;
        while (k < 40 && (64'd1 << k) < units)
            k++;
        return k;
    endfunction

    function automatic void push_span(int unsigned ord, int unsigned lo, int unsigned hi);
        int unsigned slot;
        slot = (list_head[ord] + list_count[ord]) % LIST_DEPTH;
        span_lo[ord][slot] = lo;
        span_hi[ord][slot] = hi;
        list_count[ord]++;
    endfunction

    function automatic void load_pool(logic [POOL_W-1:0] size);
        longint unsigned units;
        units = 64'(size);
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            list_head[i]  = 0;
            list_count[i] = 0;
        end
        if (units == 0)
            return;
        if (units > (64'd1 << MAX_ORDER))
            units = 64'd1 << MAX_ORDER;
        push_span(order_for(units), 0, 32'(units - 1));
    endfunction

    function automatic grant_t allocate(logic [REQ_W-1:0] req);
        int unsigned want_ord;
        int unsigned found;
        int unsigned lvl;
        int unsigned lo;
        int unsigned hi;
        int unsigned w;
        grant_t      g;
        g.status     = STAT_NOSPACE;
        g.block_low  = '0;
        g.block_high = '0;
        want_ord = order_for(64'(req));
        if (want_ord > MAX_ORDER)
            return g;
        found = want_ord;
        while (found <= MAX_ORDER && list_count[found] == 0)
            found++;
        if (found > MAX_ORDER)
            return g;
        for (lvl = want_ord; lvl < found; lvl++)
        begin
            if (list_count[lvl] >= LIST_DEPTH)
            begin
                g.status = STAT_FULL;
                return g;
            end
        end
        lo = span_lo[found][list_head[found]];
        hi = span_hi[found][list_head[found]];
        list_head[found] = (list_head[found] + 1) % LIST_DEPTH;
        list_count[found]--;
        // halve down to the request order: queue upper, keep lower
        lvl = found;
        while (lvl > want_ord)
        begin
            w = hi - lo;
            lvl--;
            push_span(lvl, lo + (w + 1) / 2, hi);
            hi = lo + w / 2;
        end
        g.status     = STAT_OK;
        g.block_low  = lo[BOUND_OUT_W-1:0];
        g.block_high = hi[BOUND_OUT_W-1:0];
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        grant_t got;
        grant_t want;
        if (!rst_n)
        begin
            grants_due.delete();
            load_pool(POOL_RESET);
            grants_pending <= 1'b0;
        end
        else
        begin
            if (pool_size_we)
                load_pool(pool_size_wdata);
            if (s_tvalid && s_tready)
                grants_due = {grants_due, allocate(s_tdata[REQ_W-1:0])};
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata};
                if (grants_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual status %0d low %0d high %0d",
                             $time, got.status, got.block_low, got.block_high);
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (want.status == STAT_OK)
                        grants++;
                    if (got.status !== want.status)
                    begin
                        fails++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.block_low !== want.block_low)
                    begin
                        fails++;
                        $display("%0t: block_low expected %0d actual %0d",
                                 $time, want.block_low, got.block_low);
                    end
                    if (got.block_high !== want.block_high)
                    begin
                        fails++;
                        $display("%0t: block_high expected %0d actual %0d",
                                 $time, want.block_high, got.block_high);
                    end
                end
            end
            grants_pending <= (grants_due.size() != 0);
        end
    end

endmodule

>>> tb/buddy_block_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// Buddy allocator testbench
// Drives allocation requests and pool-size writes into the allocator with
// random gaps and output stalls. Starts with directed requests on edge sizes
// and odd pools, then runs phases that each reload a pool and issue random
// requests against it. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buddy_block_allocator_unit_tb;
    import bba_pkg::*;

    localparam int MAX_ORDER    = 16;
    localparam int LIST_DEPTH   = 64;
    localparam int ITEM_TARGET  = 1220;
    localparam int DRAIN_CYCLES = 2 * MAX_ORDER + 8;
    localparam int CYCLE_LIMIT  = 800000;
    localparam logic [POOL_W-1:0] POOL_MAX = {POOL_W{1'b1}};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;
    logic                 pool_size_we = 1'b0;
    logic [POOL_W-1:0]    pool_size_wdata = '0;

    logic                 steady = 1'b0;
    logic [POOL_W-1:0]    pool_now = POOL_RESET;
    int                   requests = 0;
    int                   pool_loads = 0;
    int                   cycles = 0;
    int                   mismatch_count;
    int                   grant_count;
    logic                 grants_pending;

    initial
    begin
        forever #5 clk = ~clk;
    end

    buddy_block_allocator_unit #(
        .MAX_ORDER  (MAX_ORDER),
        .LIST_DEPTH (LIST_DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .pool_size_we    (pool_size_we),
        .pool_size_wdata (pool_size_wdata)
    );

    buddy_block_allocator_unit_checker #(
        .MAX_ORDER  (MAX_ORDER),
        .LIST_DEPTH (LIST_DEPTH)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .pool_size_we    (pool_size_we),
        .pool_size_wdata (pool_size_wdata),
        .mismatch_count  (mismatch_count),
        .grant_count     (grant_count),
        .grants_pending  (grants_pending)
    );

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 16);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] size);
        while (!steady && $urandom_range(99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-REQ_W){1'b0}}, size};
        do
            @(posedge clk);
        while (!s_tready);
        requests++;
    endtask

    task automatic set_pool(input logic [POOL_W-1:0] size);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (grants_pending);
        pool_size_we    <= 1'b1;
        pool_size_wdata <= size;
        @(posedge clk);
        pool_size_we <= 1'b0;
        pool_now = size;
        pool_loads++;
    endtask

    function automatic logic [POOL_W-1:0] pick_pool();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return '0;
        if (r < 8)
            return POOL_W'(1);
        if (r < 14)
            return POOL_RESET;
        if (r < 20)
            return POOL_MAX;
        if (r < 28)
            return POOL_W'($urandom_range(131071, 65537));
        if (r < 60)
            return POOL_W'(1 << $urandom_range(16, 0));
        return POOL_W'($urandom_range(65536, 2));
    endfunction

    function automatic logic [REQ_W-1:0] pick_size(logic [POOL_W-1:0] pool);
        int unsigned r;
        int unsigned cap_ord;
        int unsigned k;
        cap_ord = (pool > POOL_RESET) ? MAX_ORDER : $clog2(pool);
        r = $urandom_range(99);
        if (r < 3)
            return '0;
        if (r < 8)
            return REQ_W'($urandom_range(131071, 65537));
        if (r < 20)
            k = $urandom_range(MAX_ORDER, 0);
        else
            k = $urandom_range(cap_ord, 0);
        if (k == 0)
            return REQ_W'(1);
        return REQ_W'($urandom_range(1 << k, (1 << (k - 1)) + 1));
    endfunction

    initial
    begin
        int phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset pool: split all the way down, zero, whole pool, oversized
        send_request(1);
        send_request(1);
        send_request(0);
        send_request(2);
        send_request(3);
        send_request(32768);
        send_request(65536);
        send_request(131071);
        send_request(65537);

        // uneven pool halves
        set_pool(100);
        send_request(64);
        send_request(64);
        send_request(1);

        set_pool('0);
        send_request(1);
        send_request(0);

        set_pool(POOL_MAX);
        send_request(65536);
        send_request(1);

        set_pool(1);
        send_request(1);
        send_request(1);
        send_request(0);

        phase = 0;
        while (requests < ITEM_TARGET)
        begin
            steady <= (phase >= 12 && phase < 18);
            set_pool(pick_pool());
            repeat ($urandom_range(48, 16))
                send_request(pick_size(pool_now));
            phase++;
        end

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (grants_pending);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests over %0d pool loads (empty, single-unit, uneven, oversized).",
                 requests, pool_loads);
        $display("Granted %0d blocks; the remaining requests were refused.", grant_count);
        if (mismatch_count == 0 && !grants_pending)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/bba_pkg.sv
hdl/buddy_block_allocator_unit.sv
hdl/bba_checker.sv
tb/buddy_block_allocator_unit_checker.sv
tb/buddy_block_allocator_unit_tb.sv
